// ===== src/legendre_poly_eval_defines.svh =====
// Assertion macros shared by the Legendre evaluator RTL.
`ifndef LEGENDRE_POLY_EVAL_DEFINES_SVH
`define LEGENDRE_POLY_EVAL_DEFINES_SVH

// Same-cycle implication, clocked on clk_i and disabled during reset.
`define LPE_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("legendre_poly_eval: same-cycle check failed");

// Next-cycle implication, clocked on clk_i and disabled during reset.
`define LPE_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("legendre_poly_eval: next-cycle check failed");

`endif

// ===== src/lpe_pkg.sv =====
// Package with types, constants, width helpers and cell programme for the evaluator.
package lpe_pkg;

  // Fixed field widths of the transactions.
  localparam int X_W   = 16;
  localparam int DEG_W = 3;
  localparam int OUT_W = 32;

  // Default number of fraction bits.
  localparam int FRAC_BITS_DEF = 14;

  // Number of multiply-add cells in the chain.
  localparam int NUM_CELLS = 3;

  // Degree codes.
  localparam logic [DEG_W-1:0] DEG_CONST   = 3'd0;
  localparam logic [DEG_W-1:0] DEG_LINEAR  = 3'd1;
  localparam logic [DEG_W-1:0] DEG_QUAD    = 3'd2;
  localparam logic [DEG_W-1:0] DEG_CUBIC   = 3'd3;
  localparam logic [DEG_W-1:0] DEG_QUARTIC = 3'd4;
  localparam logic [DEG_W-1:0] DEG_QUINTIC = 3'd5;

  // Saturation limits of the result.
  localparam logic signed [OUT_W-1:0] OUT_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [OUT_W-1:0] OUT_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic signed [X_W-1:0] x_value;
    logic [DEG_W-1:0]      degree;
  } lpe_in_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] poly_value;
    logic                    bad_degree;
  } lpe_out_t;

  // Item context that travels alongside the accumulator.
  typedef struct packed {
    logic signed [X_W-1:0] x_value;
    logic [DEG_W-1:0]      degree;
  } lpe_side_t;

  // Multiplicand selection of a cell.
  typedef enum logic [1:0] {
    MUL_ONE,
    MUL_X,
    MUL_S
  } lpe_mul_e;

  // Additive constant of a cell, scaled by powers of the unit.
  typedef enum logic [2:0] {
    K_ZERO,
    K_M1_2F,
    K_P3_2F,
    K_M3_2F,
    K_P15_2F,
    K_M30_F,
    K_M70_F
  } lpe_coef_e;

  typedef struct packed {
    lpe_mul_e  mul;
    lpe_coef_e coef;
    logic      rnd;
  } lpe_op_t;

  function automatic int lpe_max(input int a, input int b);
    return (a > b) ? a : b;
  endfunction

  // Width of the initial accumulator (holds 2^F and the leading coefficients).
  function automatic int lpe_w0(input int f);
    return f + 2;
  endfunction

  // Width of the multiplicand: signed x or the unsigned square s.
  function automatic int lpe_mul_w(input int f);
    return lpe_max(X_W, 32 - f);
  endfunction

  // Width of the rounded square s = round(x^2 / 2^F).
  function automatic int lpe_sq_w(input int f);
    return 31 - f;
  endfunction

  // Width of the largest cell constant.
  function automatic int lpe_coef_w(input int f);
    return 2 * f + 6;
  endfunction

  // Accumulator width after the first cell.
  function automatic int lpe_w1(input int f);
    return lpe_max(lpe_max(37 - f, f + 8), 19);
  endfunction

  // Accumulator width after the second cell.
  function automatic int lpe_w2(input int f);
    int w1;
    w1 = lpe_w1(f);
    return lpe_max(lpe_max(34, 2 * f + 3), lpe_max(w1 + 32 - 2 * f, lpe_max(f + 7, w1)));
  endfunction

  // Accumulator width after the third cell.
  function automatic int lpe_w3(input int f);
    return lpe_max(lpe_w2(f) + 17, lpe_max(lpe_w1(f) + 33 - f, 2 * f + 4));
  endfunction

  // Operation of a cell for a degree: acc = acc * mul + coef, rounded by 2^F if rnd.
  function automatic lpe_op_t lpe_cell_op(input logic [DEG_W-1:0] degree, input int idx);
    lpe_op_t op;
    op = '{mul: MUL_ONE, coef: K_ZERO, rnd: 1'b0};
    unique case (idx)
      1: begin
        unique case (degree)
          DEG_CUBIC:   op = '{mul: MUL_X, coef: K_ZERO,  rnd: 1'b0};
          DEG_QUINTIC: op = '{mul: MUL_S, coef: K_M70_F, rnd: 1'b0};
          default:     op = '{mul: MUL_ONE, coef: K_ZERO, rnd: 1'b0};
        endcase
      end
      2: begin
        unique case (degree)
          DEG_QUAD:    op = '{mul: MUL_X, coef: K_ZERO,   rnd: 1'b0};
          DEG_CUBIC:   op = '{mul: MUL_X, coef: K_M3_2F,  rnd: 1'b0};
          DEG_QUARTIC: op = '{mul: MUL_S, coef: K_M30_F,  rnd: 1'b0};
          DEG_QUINTIC: op = '{mul: MUL_S, coef: K_P15_2F, rnd: 1'b1};
          default:     op = '{mul: MUL_ONE, coef: K_ZERO, rnd: 1'b0};
        endcase
      end
      default: begin
        unique case (degree)
          DEG_LINEAR:  op = '{mul: MUL_X, coef: K_ZERO,  rnd: 1'b0};
          DEG_QUAD:    op = '{mul: MUL_X, coef: K_M1_2F, rnd: 1'b0};
          DEG_CUBIC:   op = '{mul: MUL_X, coef: K_ZERO,  rnd: 1'b0};
          DEG_QUARTIC: op = '{mul: MUL_S, coef: K_P3_2F, rnd: 1'b0};
          DEG_QUINTIC: op = '{mul: MUL_X, coef: K_ZERO,  rnd: 1'b0};
          default:     op = '{mul: MUL_ONE, coef: K_ZERO, rnd: 1'b0};
        endcase
      end
    endcase
    return op;
  endfunction

endpackage

// ===== src/lpe_square.sv =====
// Front stage: squares the abscissa, rounds it and loads the leading coefficient.
module lpe_square
  import lpe_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             valid_i,
  output logic                             ready_o,
  input  lpe_in_t                          data_i,
  output logic                             valid_o,
  input  logic                             ready_i,
  output logic signed [lpe_w0(FRAC_BITS)-1:0] acc_o,
  output logic [lpe_sq_w(FRAC_BITS)-1:0]   s_o,
  output lpe_side_t                        side_o
);

  localparam int W0   = lpe_w0(FRAC_BITS);
  localparam int SQ_W = lpe_sq_w(FRAC_BITS);

  logic signed [2*X_W-1:0] sq;
  logic [2*X_W-1:0]        sq_rnd;
  logic signed [W0-1:0]    acc_d,  acc_q;
  logic [SQ_W-1:0]         s_d,    s_q;
  lpe_side_t               side_q;
  logic                    valid_q;

  // Square of x, rounded to F fraction bits; it is never negative.
  always_comb begin
    sq     = data_i.x_value * data_i.x_value;
    sq_rnd = sq + ((2*X_W)'(1) << (FRAC_BITS - 1));
    s_d    = SQ_W'(sq_rnd >> FRAC_BITS);
  end

  // Leading coefficient of the Horner evaluation for each degree.
  always_comb begin
    unique case (data_i.degree)
      DEG_CONST:   acc_d = W0'(1) <<< FRAC_BITS;
      DEG_LINEAR:  acc_d = W0'(1);
      DEG_QUAD:    acc_d = W0'(3);
      DEG_CUBIC:   acc_d = W0'(5);
      DEG_QUARTIC: acc_d = W0'(35);
      DEG_QUINTIC: acc_d = W0'(63);
      default:     acc_d = '0;
    endcase
  end

  assign ready_o = !valid_q || ready_i;

  // Stage register; it advances whenever the next stage can take the transaction.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      acc_q  <= acc_d;
      s_q    <= s_d;
      side_q <= '{x_value: data_i.x_value, degree: data_i.degree};
    end
  end

  assign valid_o = valid_q;
  assign acc_o   = acc_q;
  assign s_o     = s_q;
  assign side_o  = side_q;

endmodule

// ===== src/lpe_cell.sv =====
// Multiply-add cell of the chain: acc = acc * (1, x or s) + constant, optionally rounded.
module lpe_cell
  import lpe_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int CELL_IDX  = 1,
  parameter int IN_W      = lpe_w0(FRAC_BITS),
  parameter int OUT_W     = lpe_w1(FRAC_BITS)
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           valid_i,
  output logic                           ready_o,
  input  logic signed [IN_W-1:0]         acc_i,
  input  logic [lpe_sq_w(FRAC_BITS)-1:0] s_i,
  input  lpe_side_t                      side_i,
  output logic                           valid_o,
  input  logic                           ready_i,
  output logic signed [OUT_W-1:0]        acc_o,
  output logic [lpe_sq_w(FRAC_BITS)-1:0] s_o,
  output lpe_side_t                      side_o
);

  localparam int MW   = lpe_mul_w(FRAC_BITS);
  localparam int SQ_W = lpe_sq_w(FRAC_BITS);
  localparam int KW   = lpe_coef_w(FRAC_BITS);
  localparam int PW   = IN_W + MW;
  localparam int SW   = lpe_max(PW, KW) + 2;

  lpe_op_t               op;
  logic signed [MW-1:0]  mul_op;
  logic signed [KW-1:0]  coef;
  logic signed [PW-1:0]  prod;
  logic signed [SW-1:0]  sum;
  logic signed [SW-1:0]  sum_rnd;
  logic signed [OUT_W-1:0] acc_d, acc_q;
  logic [SQ_W-1:0]       s_q;
  lpe_side_t             side_q;
  logic                  valid_q;

  // Decode this cell's step of the programme for the item's degree.
  always_comb begin
    op = lpe_cell_op(side_i.degree, CELL_IDX);
  end

  // Multiplicand selection.
  always_comb begin
    unique case (op.mul)
      MUL_X:   mul_op = MW'(side_i.x_value);
      MUL_S:   mul_op = MW'($signed({1'b0, s_i}));
      default: mul_op = MW'(1);
    endcase
  end

  // Constant term, scaled by the unit or its square.
  always_comb begin
    unique case (op.coef)
      K_M1_2F:  coef = -(KW'(1) <<< (2 * FRAC_BITS));
      K_P3_2F:  coef = KW'(3) <<< (2 * FRAC_BITS);
      K_M3_2F:  coef = -(KW'(3) <<< (2 * FRAC_BITS));
      K_P15_2F: coef = KW'(15) <<< (2 * FRAC_BITS);
      K_M30_F:  coef = -(KW'(30) <<< FRAC_BITS);
      K_M70_F:  coef = -(KW'(70) <<< FRAC_BITS);
      default:  coef = '0;
    endcase
  end

  // Multiply-add with round-half-up by 2^F where the programme asks for it.
  always_comb begin
    prod    = acc_i * mul_op;
    sum     = SW'(prod) + SW'(coef);
    sum_rnd = (sum + (SW'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    acc_d   = op.rnd ? OUT_W'(sum_rnd) : OUT_W'(sum);
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      acc_q  <= acc_d;
      s_q    <= s_i;
      side_q <= side_i;
    end
  end

  assign valid_o = valid_q;
  assign acc_o   = acc_q;
  assign s_o     = s_q;
  assign side_o  = side_q;

endmodule

// ===== src/lpe_round_sat.sv =====
// Output stage: final rounding shift per degree, saturation and the degree check.
module lpe_round_sat
  import lpe_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int IN_W      = lpe_w3(FRAC_BITS)
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    valid_i,
  output logic                    ready_o,
  input  logic signed [IN_W-1:0]  acc_i,
  input  logic [DEG_W-1:0]        degree_i,
  output logic                    valid_o,
  input  logic                    ready_i,
  output lpe_out_t                data_o
);

  localparam int VW = IN_W + 1;

  logic signed [VW-1:0] v_ext;
  logic signed [VW-1:0] shifted;
  lpe_out_t             data_d, data_q;
  logic                 valid_q;

  // Final scaling back to F fraction bits, rounding half up.
  always_comb begin
    v_ext = VW'(acc_i);
    case (degree_i) inside
      DEG_CONST, DEG_LINEAR:
        shifted = v_ext;
      DEG_QUAD:
        shifted = (v_ext + (VW'(1) <<< FRAC_BITS)) >>> (FRAC_BITS + 1);
      DEG_CUBIC:
        shifted = (v_ext + (VW'(1) <<< (2 * FRAC_BITS))) >>> (2 * FRAC_BITS + 1);
      DEG_QUARTIC, DEG_QUINTIC:
        shifted = (v_ext + (VW'(1) <<< (FRAC_BITS + 2))) >>> (FRAC_BITS + 3);
      default:
        shifted = '0;
    endcase
  end

  // Saturate to 32 bits; an unsupported degree gives zero and the flag.
  always_comb begin
    if (degree_i > DEG_QUINTIC) begin
      data_d = '{poly_value: '0, bad_degree: 1'b1};
    end else if (shifted > VW'(OUT_MAX)) begin
      data_d = '{poly_value: OUT_MAX, bad_degree: 1'b0};
    end else if (shifted < VW'(OUT_MIN)) begin
      data_d = '{poly_value: OUT_MIN, bad_degree: 1'b0};
    end else begin
      data_d = '{poly_value: OUT_W'(shifted), bad_degree: 1'b0};
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ===== src/legendre_poly_eval.sv =====
// Top level of the Legendre polynomial evaluator, degrees 0 to 5.
//
// Each input transaction carries a signed abscissa with FRAC_BITS fraction bits and a
// degree; each produces exactly one result transaction holding P_degree(x) with
// FRAC_BITS fraction bits, saturated to 32 bits, plus a flag for degrees 6 and 7
// (whose value is then zero). The evaluator is a five-stage pipeline: a squaring
// stage, a chain of three multiply-add cells that each run one step of a Horner
// programme chosen by the degree, and a rounding and saturation stage that is also
// the output register. It accepts one transaction per clock cycle when the output is
// not stalled. Each transaction passes the squaring register, the three cell
// registers and the output register before its result is offered. Every stage holds
// its own valid bit, so empty stages fill while a finished result waits to be taken.
`include "legendre_poly_eval_defines.svh"

module legendre_poly_eval
  import lpe_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  lpe_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output lpe_out_t out_data_o
);

  localparam int W0   = lpe_w0(FRAC_BITS);
  localparam int W1   = lpe_w1(FRAC_BITS);
  localparam int W2   = lpe_w2(FRAC_BITS);
  localparam int W3   = lpe_w3(FRAC_BITS);
  localparam int SQ_W = lpe_sq_w(FRAC_BITS);

  logic                 v0, v1, v2, v3;
  logic                 r0, r1, r2, r3;
  logic signed [W0-1:0] acc0;
  logic signed [W1-1:0] acc1;
  logic signed [W2-1:0] acc2;
  logic signed [W3-1:0] acc3;
  logic [SQ_W-1:0]      s0, s1, s2;
  lpe_side_t            side0, side1, side2, side3;

  // Squaring stage and leading coefficient.
  lpe_square #(
    .FRAC_BITS (FRAC_BITS)
  ) u_square (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .ready_o (in_ready_o),
    .data_i  (in_data_i),
    .valid_o (v0),
    .ready_i (r0),
    .acc_o   (acc0),
    .s_o     (s0),
    .side_o  (side0)
  );

  // Chain of multiply-add cells.
  lpe_cell #(
    .FRAC_BITS (FRAC_BITS),
    .CELL_IDX  (1),
    .IN_W      (W0),
    .OUT_W     (W1)
  ) u_cell1 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v0),
    .ready_o (r0),
    .acc_i   (acc0),
    .s_i     (s0),
    .side_i  (side0),
    .valid_o (v1),
    .ready_i (r1),
    .acc_o   (acc1),
    .s_o     (s1),
    .side_o  (side1)
  );

  lpe_cell #(
    .FRAC_BITS (FRAC_BITS),
    .CELL_IDX  (2),
    .IN_W      (W1),
    .OUT_W     (W2)
  ) u_cell2 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v1),
    .ready_o (r1),
    .acc_i   (acc1),
    .s_i     (s1),
    .side_i  (side1),
    .valid_o (v2),
    .ready_i (r2),
    .acc_o   (acc2),
    .s_o     (s2),
    .side_o  (side2)
  );

  lpe_cell #(
    .FRAC_BITS (FRAC_BITS),
    .CELL_IDX  (NUM_CELLS),
    .IN_W      (W2),
    .OUT_W     (W3)
  ) u_cell3 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v2),
    .ready_o (r2),
    .acc_i   (acc2),
    .s_i     (s2),
    .side_i  (side2),
    .valid_o (v3),
    .ready_i (r3),
    .acc_o   (acc3),
    .s_o     (),
    .side_o  (side3)
  );

  // Final rounding, saturation and output register.
  lpe_round_sat #(
    .FRAC_BITS (FRAC_BITS),
    .IN_W      (W3)
  ) u_round_sat (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (v3),
    .ready_o  (r3),
    .acc_i    (acc3),
    .degree_i (side3.degree),
    .valid_o  (out_valid_o),
    .ready_i  (out_ready_i),
    .data_o   (out_data_o)
  );

  // A ready sink lets the whole pipeline move, so the input side is open too.
  `LPE_ASSERT_IMP(a_ready_flows, out_ready_i, in_ready_o)
  // The linear programme must leave x unchanged at the end of the cell chain.
  `LPE_ASSERT_IMP(a_linear_passes, v3 && (side3.degree == DEG_LINEAR), acc3 == W3'(side3.x_value))
  // A last-cell transaction taken by a free output stage shows up as a result next cycle.
  `LPE_ASSERT_NXT(a_result_loaded, v3 && r3, out_valid_o)
  // An unsupported degree always comes out as zero.
  `LPE_ASSERT_IMP(a_bad_is_zero, out_valid_o && out_data_o.bad_degree, out_data_o.poly_value == '0)

endmodule
